/* design/c8ie_pkg.sv */
// Package for the CHIP-8 instruction execute block.
// Holds the sequencer states, status codes, opcode codes, the ALU result struct and the font.
// Depends on nothing.
package c8ie_pkg;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_WAIT_KEY  = 3'd1,
		ST_UNKNOWN   = 3'd2,
		ST_OVERFLOW  = 3'd3,
		ST_UNDERFLOW = 3'd4,
		ST_DISPLAY   = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_FL, S_RX, S_RY, S_EX, S_VF, S_POP,
		S_BCD1, S_BCD2, S_ST_RD, S_ST_WR, S_LD_RD, S_LD_WR
	} state_t;

	// Step modes.
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_EXEC  = 2'd1;
	localparam logic [1:0] MODE_TICK  = 2'd2;

	// Configuration register indexes.
	localparam logic [1:0] CFG_VF_RESET  = 2'd0;
	localparam logic [1:0] CFG_SHIFT_IP  = 2'd1;
	localparam logic [1:0] CFG_JUMP_VX   = 2'd2;
	localparam logic [1:0] CFG_IDX_ADV   = 2'd3;

	// Opcode groups (top nibble).
	localparam logic [3:0] OP_SYS    = 4'h0;
	localparam logic [3:0] OP_JP     = 4'h1;
	localparam logic [3:0] OP_CALL   = 4'h2;
	localparam logic [3:0] OP_SE_NN  = 4'h3;
	localparam logic [3:0] OP_SNE_NN = 4'h4;
	localparam logic [3:0] OP_SE_XY  = 4'h5;
	localparam logic [3:0] OP_LD_NN  = 4'h6;
	localparam logic [3:0] OP_ADD_NN = 4'h7;
	localparam logic [3:0] OP_ALU    = 4'h8;
	localparam logic [3:0] OP_SNE_XY = 4'h9;
	localparam logic [3:0] OP_LD_I   = 4'hA;
	localparam logic [3:0] OP_JP_V   = 4'hB;
	localparam logic [3:0] OP_RND    = 4'hC;
	localparam logic [3:0] OP_DRW    = 4'hD;
	localparam logic [3:0] OP_KEY    = 4'hE;
	localparam logic [3:0] OP_MISC   = 4'hF;

	// ALU functions (low nibble of 8XYN).
	localparam logic [3:0] ALU_MOV = 4'h0;
	localparam logic [3:0] ALU_OR  = 4'h1;
	localparam logic [3:0] ALU_AND = 4'h2;
	localparam logic [3:0] ALU_XOR = 4'h3;
	localparam logic [3:0] ALU_ADD = 4'h4;
	localparam logic [3:0] ALU_SUB = 4'h5;
	localparam logic [3:0] ALU_SHR = 4'h6;
	localparam logic [3:0] ALU_SBN = 4'h7;
	localparam logic [3:0] ALU_SHL = 4'hE;

	// System and misc low bytes.
	localparam logic [7:0] SYS_RET     = 8'hEE;
	localparam logic [7:0] SYS_CLS     = 8'hE0;
	localparam logic [7:0] SYS_SCR_R   = 8'hFB;
	localparam logic [7:0] SYS_SCR_L   = 8'hFC;
	localparam logic [7:0] SYS_LORES   = 8'hFE;
	localparam logic [7:0] SYS_HIRES   = 8'hFF;
	localparam logic [3:0] SYS_SCR_DN  = 4'hC;
	localparam logic [3:0] SYS_SCR_UP  = 4'hD;
	localparam logic [7:0] KEY_DOWN    = 8'h9E;
	localparam logic [7:0] KEY_UP      = 8'hA1;
	localparam logic [7:0] F_GET_DT    = 8'h07;
	localparam logic [7:0] F_WAIT_KEY  = 8'h0A;
	localparam logic [7:0] F_SET_DT    = 8'h15;
	localparam logic [7:0] F_SET_ST    = 8'h18;
	localparam logic [7:0] F_ADD_I     = 8'h1E;
	localparam logic [7:0] F_FONT      = 8'h29;
	localparam logic [7:0] F_BIG_FONT  = 8'h30;
	localparam logic [7:0] F_BCD       = 8'h33;
	localparam logic [7:0] F_STORE     = 8'h55;
	localparam logic [7:0] F_LOAD      = 8'h65;
	localparam logic [7:0] F_STORE_RPL = 8'h75;
	localparam logic [7:0] F_LOAD_RPL  = 8'h85;

	localparam logic [15:0] BIG_FONT_BASE = 16'h0050;

	typedef struct packed {
		logic       ok;
		logic [7:0] res;
		logic       vf_we;
		logic       vf;
	} alu_res_t;

	// Small font at 0, large font at 0x50, padded with zeros to 256 bytes.
	localparam logic [7:0] FONT [256] = '{
		8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
		8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
		8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
		8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
		8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
		8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
		8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
		8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80,
		8'hff,8'hff,8'hc3,8'hc3,8'hc3,8'hc3,8'hc3,8'hc3,8'hff,8'hff,
		8'h18,8'h78,8'h78,8'h18,8'h18,8'h18,8'h18,8'h18,8'hff,8'hff,
		8'hff,8'hff,8'h03,8'h03,8'hff,8'hff,8'hc0,8'hc0,8'hff,8'hff,
		8'hff,8'hff,8'h03,8'h03,8'hff,8'hff,8'h03,8'h03,8'hff,8'hff,
		8'hc3,8'hc3,8'hc3,8'hc3,8'hff,8'hff,8'h03,8'h03,8'h03,8'h03,
		8'hff,8'hff,8'hc0,8'hc0,8'hff,8'hff,8'h03,8'h03,8'hff,8'hff,
		8'hff,8'hff,8'hc0,8'hc0,8'hff,8'hff,8'hc3,8'hc3,8'hff,8'hff,
		8'hff,8'hff,8'h03,8'h03,8'h06,8'h0c,8'h18,8'h18,8'h18,8'h18,
		8'hff,8'hff,8'hc3,8'hc3,8'hff,8'hff,8'hc3,8'hc3,8'hff,8'hff,
		8'hff,8'hff,8'hc3,8'hc3,8'hff,8'hff,8'h03,8'h03,8'hff,8'hff,
		8'h7e,8'hff,8'hc3,8'hc3,8'hc3,8'hff,8'hff,8'hc3,8'hc3,8'hc3,
		8'hfc,8'hfc,8'hc3,8'hc3,8'hfc,8'hfc,8'hc3,8'hc3,8'hfc,8'hfc,
		8'h3c,8'hff,8'hc3,8'hc0,8'hc0,8'hc0,8'hc0,8'hc3,8'hff,8'h3c,
		8'hfc,8'hfe,8'hc3,8'hc3,8'hc3,8'hc3,8'hc3,8'hc3,8'hfe,8'hfc,
		8'hff,8'hff,8'hc0,8'hc0,8'hff,8'hff,8'hc0,8'hc0,8'hff,8'hff,
		8'hff,8'hff,8'hc0,8'hc0,8'hff,8'hff,8'hc0,8'hc0,8'hc0,8'hc0,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,
		8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00,8'h00
	};

endpackage

/* design/chip8_instruction_execute.sv */
// Top level of the CHIP-8 instruction execute block: sequencer, registers and the three RAMs.
// Depends on c8ie_pkg, c8ie_ram and c8ie_alu.
//
// After reset the block writes the font and zeros into its byte memory and zeros into its
// register file, with busy high; configuration writes are taken throughout. A memory
// write or a timer tick is finished straight from the idle state. An instruction passes
// through the fetch, register read and execute states, and BCD and register store or load
// add further states, as the byte memory and the register file each have a single port.
// Each result word appears for one cycle with done high and cannot be held off. MEM_DEPTH
// must be a power of two.
module chip8_instruction_execute
	import c8ie_pkg::*;
#(
	parameter int MEM_DEPTH     = 4096,
	parameter int STACK_DEPTH   = 16,
	parameter int PROGRAM_START = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  mode,
	input  logic [11:0] mem_addr,
	input  logic [7:0]  mem_data,
	input  logic [15:0] keys_down,
	input  logic [7:0]  random_byte,
	output logic        done,
	output logic [11:0] next_pc,
	output logic [15:0] opcode_done,
	output logic [2:0]  status,
	output logic        sound_on,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic        cfg_data
);

	localparam int AW = $clog2(MEM_DEPTH);
	localparam int SW = $clog2(STACK_DEPTH);

	state_t st_q, next_st;

	logic vf_reset_q, shift_ip_q, jump_vx_q, idx_adv_q;
	logic [AW-1:0] clr_q;
	logic [11:0] pc_q, pc_d;
	logic [15:0] idx_q, idx_d;
	logic [SW:0] sc_q, sc_d;
	logic [7:0]  dly_q, dly_d, snd_q, snd_d;
	logic        flag_q, flag_d;
	logic [3:0]  hk_q, hk_d, cnt_q, cnt_d;
	logic [7:0]  op_hi_q, op_lo_q, vx_q;
	logic [15:0] keys_q;
	logic [7:0]  rnd_q;
	logic        vf_q;
	logic [3:0]  bcd_t_q, bcd_o_q;
	logic        done_q, sound_q;
	logic [11:0] npc_q;
	logic [15:0] op_q;
	status_t     status_q;

	logic [AW-1:0] mem_a;
	logic          mem_we;
	logic [7:0]    mem_wd, mem_rd;
	logic [3:0]    reg_a;
	logic          reg_we;
	logic [7:0]    reg_wd, reg_rd;
	logic [SW-1:0] stk_a;
	logic          stk_we;
	logic [11:0]   stk_wd, stk_rd;
	logic          fin, fin_op;
	status_t       fin_st;
	alu_res_t      alu;

	logic [3:0]  x, y, low_key;
	logic [7:0]  nn;
	logic [11:0] nnn;
	logic [15:0] idx_cnt, idx_one, idx_two;
	logic [1:0]  bcd_h;
	logic [7:0]  bcd_r;
	logic [14:0] bcd_m;
	logic [3:0]  bcd_t;
	logic [7:0]  bcd_o;
	logic        key_dn;

	assign x       = op_hi_q[3:0];
	assign y       = op_lo_q[7:4];
	assign nn      = op_lo_q;
	assign nnn     = {op_hi_q[3:0], op_lo_q};
	assign idx_cnt = idx_q + {12'h000, cnt_q};
	assign idx_one = idx_q + 16'd1;
	assign idx_two = idx_q + 16'd2;
	assign key_dn  = (vx_q[7:4] == 4'h0) && keys_q[vx_q[3:0]];

	// Decimal digits of Vx: hundreds by compare, tens by reciprocal multiply.
	assign bcd_h = (vx_q >= 8'd200) ? 2'd2 : ((vx_q >= 8'd100) ? 2'd1 : 2'd0);
	assign bcd_r = vx_q - {6'b0, bcd_h} * 8'd100;
	assign bcd_m = {7'b0, bcd_r} * 15'd205;
	assign bcd_t = bcd_m[14:11];
	assign bcd_o = bcd_r - {4'h0, bcd_t} * 8'd10;

	// Lowest held key.
	always_comb begin
		low_key = 4'h0;
		for (int k = 15; k >= 0; k--) begin
			if (keys_q[k]) begin
				low_key = 4'(k);
			end
		end
	end

	c8ie_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_mem (
		.clk(clk), .we(mem_we), .addr(mem_a), .wdata(mem_wd), .rdata(mem_rd)
	);

	c8ie_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
		.clk(clk), .we(reg_we), .addr(reg_a), .wdata(reg_wd), .rdata(reg_rd)
	);

	c8ie_ram #(.WIDTH(12), .DEPTH(STACK_DEPTH)) u_stack (
		.clk(clk), .we(stk_we), .addr(stk_a), .wdata(stk_wd), .rdata(stk_rd)
	);

	c8ie_alu u_alu (
		.fn(op_lo_q[3:0]), .vx(vx_q), .vy(reg_rd),
		.vf_reset_mode(vf_reset_q), .shift_in_place(shift_ip_q), .res(alu)
	);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLEAR;
		end else begin
			st_q <= next_st;
		end
	end

	// Next state, RAM ports and next architectural state.
	always_comb begin
		next_st = st_q;
		mem_a   = AW'(pc_q);
		mem_we  = 1'b0;
		mem_wd  = 8'h00;
		reg_a   = 4'h0;
		reg_we  = 1'b0;
		reg_wd  = 8'h00;
		stk_a   = SW'(sc_q);
		stk_we  = 1'b0;
		stk_wd  = pc_q;
		pc_d    = pc_q;
		idx_d   = idx_q;
		sc_d    = sc_q;
		dly_d   = dly_q;
		snd_d   = snd_q;
		flag_d  = flag_q;
		hk_d    = hk_q;
		cnt_d   = cnt_q;
		fin     = 1'b0;
		fin_op  = 1'b1;
		fin_st  = ST_OK;
		case (st_q)
			S_CLEAR: begin
				mem_a  = clr_q;
				mem_we = 1'b1;
				mem_wd = (clr_q < AW'(256)) ? FONT[clr_q[7:0]] : 8'h00;
				// The register file is zeroed alongside the byte memory.
				reg_a  = clr_q[3:0];
				reg_we = 1'b1;
				if (clr_q == AW'(MEM_DEPTH - 1)) begin
					next_st = S_IDLE;
				end
			end
			S_IDLE: begin
				fin_op = 1'b0;
				if (start) begin
					case (mode)
						MODE_WRITE: begin
							mem_a  = AW'(mem_addr);
							mem_we = 1'b1;
							mem_wd = mem_data;
							fin    = 1'b1;
						end
						MODE_EXEC: next_st = S_FL;
						MODE_TICK: begin
							if (dly_q != 8'h00) dly_d = dly_q - 8'd1;
							if (snd_q != 8'h00) snd_d = snd_q - 8'd1;
							fin = 1'b1;
						end
						default: fin = 1'b1;
					endcase
				end
			end
			S_FL: begin
				mem_a   = AW'(pc_q + 12'd1);
				next_st = S_RX;
			end
			S_RX: begin
				reg_a   = op_hi_q[3:0];
				pc_d    = pc_q + 12'd2;
				next_st = S_RY;
			end
			S_RY: begin
				reg_a   = (op_hi_q[7:4] == OP_JP_V) ? (jump_vx_q ? x : 4'h0) : y;
				next_st = S_EX;
			end
			S_EX: begin
				fin = 1'b1;
				case (op_hi_q[7:4])
					OP_SYS: begin
						if (x != 4'h0) begin
							fin_st = ST_UNKNOWN;
						end else if (nn == SYS_RET) begin
							if (sc_q == '0) begin
								fin_st = ST_UNDERFLOW;
							end else begin
								sc_d    = sc_q - 1'b1;
								stk_a   = SW'(sc_q - 1'b1);
								fin     = 1'b0;
								next_st = S_POP;
							end
						end else if (nn == SYS_CLS || nn == SYS_SCR_R || nn == SYS_SCR_L ||
								nn == SYS_LORES || nn == SYS_HIRES ||
								nn[7:4] == SYS_SCR_DN || nn[7:4] == SYS_SCR_UP) begin
							fin_st = ST_DISPLAY;
						end else begin
							fin_st = ST_UNKNOWN;
						end
					end
					OP_JP: pc_d = nnn;
					OP_CALL: begin
						if (sc_q >= (SW+1)'(STACK_DEPTH)) begin
							fin_st = ST_OVERFLOW;
						end else begin
							stk_we = 1'b1;
							sc_d   = sc_q + 1'b1;
							pc_d   = nnn;
						end
					end
					OP_SE_NN:  if (vx_q == nn) pc_d = pc_q + 12'd2;
					OP_SNE_NN: if (vx_q != nn) pc_d = pc_q + 12'd2;
					OP_SE_XY:  if (vx_q == reg_rd) pc_d = pc_q + 12'd2;
					OP_SNE_XY: if (vx_q != reg_rd) pc_d = pc_q + 12'd2;
					OP_LD_NN: begin reg_a = x; reg_we = 1'b1; reg_wd = nn; end
					OP_ADD_NN: begin reg_a = x; reg_we = 1'b1; reg_wd = vx_q + nn; end
					OP_ALU: begin
						if (!alu.ok) begin
							fin_st = ST_UNKNOWN;
						end else begin
							reg_a  = x;
							reg_we = 1'b1;
							reg_wd = alu.res;
							if (alu.vf_we) begin
								fin     = 1'b0;
								next_st = S_VF;
							end
						end
					end
					OP_LD_I: idx_d = {4'h0, nnn};
					OP_JP_V: pc_d = nnn + {4'h0, reg_rd};
					OP_RND: begin reg_a = x; reg_we = 1'b1; reg_wd = rnd_q & nn; end
					OP_DRW: fin_st = ST_DISPLAY;
					OP_KEY: begin
						if (nn == KEY_DOWN) begin
							if (key_dn) pc_d = pc_q + 12'd2;
						end else if (nn == KEY_UP) begin
							if (!key_dn) pc_d = pc_q + 12'd2;
						end else begin
							fin_st = ST_UNKNOWN;
						end
					end
					default: begin
						case (nn)
							F_GET_DT: begin reg_a = x; reg_we = 1'b1; reg_wd = dly_q; end
							F_SET_DT: dly_d = vx_q;
							F_SET_ST: snd_d = vx_q;
							F_ADD_I:  idx_d = idx_q + {8'h00, vx_q};
							F_WAIT_KEY: begin
								if (keys_q != 16'h0000) begin
									hk_d   = low_key;
									flag_d = 1'b1;
									pc_d   = pc_q - 12'd2;
									fin_st = ST_WAIT_KEY;
								end else if (flag_q) begin
									reg_a  = x;
									reg_we = 1'b1;
									reg_wd = {4'h0, hk_q};
									flag_d = 1'b0;
								end else begin
									pc_d   = pc_q - 12'd2;
									fin_st = ST_WAIT_KEY;
								end
							end
							F_FONT:     idx_d = {8'h00, vx_q} * 16'd5;
							F_BIG_FONT: idx_d = BIG_FONT_BASE + {8'h00, vx_q} * 16'd10;
							F_BCD: begin
								mem_a   = idx_q[AW-1:0];
								mem_we  = 1'b1;
								mem_wd  = {6'b0, bcd_h};
								fin     = 1'b0;
								next_st = S_BCD1;
							end
							F_STORE, F_STORE_RPL: begin
								cnt_d   = 4'h0;
								fin     = 1'b0;
								next_st = S_ST_RD;
							end
							F_LOAD, F_LOAD_RPL: begin
								cnt_d   = 4'h0;
								fin     = 1'b0;
								next_st = S_LD_RD;
							end
							default: fin_st = ST_UNKNOWN;
						endcase
					end
				endcase
			end
			S_VF: begin
				reg_a  = 4'hF;
				reg_we = 1'b1;
				reg_wd = {7'b0, vf_q};
				fin    = 1'b1;
			end
			S_POP: begin
				pc_d = stk_rd;
				fin  = 1'b1;
			end
			S_BCD1: begin
				mem_a   = idx_one[AW-1:0];
				mem_we  = 1'b1;
				mem_wd  = {4'h0, bcd_t_q};
				next_st = S_BCD2;
			end
			S_BCD2: begin
				mem_a  = idx_two[AW-1:0];
				mem_we = 1'b1;
				mem_wd = {4'h0, bcd_o_q};
				fin    = 1'b1;
			end
			S_ST_RD: begin
				reg_a   = cnt_q;
				next_st = S_ST_WR;
			end
			S_ST_WR: begin
				mem_a  = idx_cnt[AW-1:0];
				mem_we = 1'b1;
				mem_wd = reg_rd;
				if (cnt_q == x) begin
					if (idx_adv_q) idx_d = idx_q + {12'h000, x} + 16'd1;
					fin = 1'b1;
				end else begin
					cnt_d   = cnt_q + 4'd1;
					next_st = S_ST_RD;
				end
			end
			S_LD_RD: begin
				mem_a   = idx_cnt[AW-1:0];
				next_st = S_LD_WR;
			end
			S_LD_WR: begin
				reg_a  = cnt_q;
				reg_we = 1'b1;
				reg_wd = mem_rd;
				if (cnt_q == x) begin
					if (idx_adv_q) idx_d = idx_q + {12'h000, x} + 16'd1;
					fin = 1'b1;
				end else begin
					cnt_d   = cnt_q + 4'd1;
					next_st = S_LD_RD;
				end
			end
			default: next_st = S_IDLE;
		endcase
		if (fin) begin
			next_st = S_IDLE;
		end
	end

	// Architectural control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			pc_q   <= 12'(PROGRAM_START);
			idx_q  <= 16'h0000;
			sc_q   <= '0;
			dly_q  <= 8'h00;
			snd_q  <= 8'h00;
			flag_q <= 1'b0;
			hk_q   <= 4'h0;
			cnt_q  <= 4'h0;
			done_q <= 1'b0;
		end else begin
			if (st_q == S_CLEAR) clr_q <= clr_q + 1'b1;
			pc_q   <= pc_d;
			idx_q  <= idx_d;
			sc_q   <= sc_d;
			dly_q  <= dly_d;
			snd_q  <= snd_d;
			flag_q <= flag_d;
			hk_q   <= hk_d;
			cnt_q  <= cnt_d;
			done_q <= fin;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vf_reset_q <= 1'b1;
			shift_ip_q <= 1'b0;
			jump_vx_q  <= 1'b0;
			idx_adv_q  <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_VF_RESET: vf_reset_q <= cfg_data;
				CFG_SHIFT_IP: shift_ip_q <= cfg_data;
				CFG_JUMP_VX:  jump_vx_q  <= cfg_data;
				CFG_IDX_ADV:  idx_adv_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Operand captures and result word.
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start) begin
			keys_q <= keys_down;
			rnd_q  <= random_byte;
		end
		if (st_q == S_FL) op_hi_q <= mem_rd;
		if (st_q == S_RX) op_lo_q <= mem_rd;
		if (st_q == S_RY) vx_q <= reg_rd;
		if (st_q == S_EX) begin
			vf_q    <= alu.vf;
			bcd_t_q <= bcd_t;
			bcd_o_q <= bcd_o[3:0];
		end
		if (fin) begin
			npc_q    <= pc_d;
			op_q     <= fin_op ? {op_hi_q, op_lo_q} : 16'h0000;
			status_q <= fin_st;
			sound_q  <= (snd_d != 8'h00);
		end
	end

	assign busy        = (st_q != S_IDLE);
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign next_pc     = npc_q;
	assign opcode_done = op_q;
	assign status      = status_q;
	assign sound_on    = sound_q;

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sc_q <= (SW+1)'(STACK_DEPTH)) else $error("stack count beyond depth");
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done_q)) else $error("accepted word went nowhere");
	a_no_result_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_CLEAR) |-> !done_q) else $error("result during memory clear");
	a_done_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(fin)) else $error("result without finish");

endmodule

/* design/c8ie_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// Depends on nothing.
module c8ie_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read before write: the registered read data shows the old word at a written address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

/* design/c8ie_alu.sv */
// Arithmetic and logic unit for the 8XYN instruction group.
// Depends on c8ie_pkg.
module c8ie_alu
	import c8ie_pkg::*;
(
	input  logic [3:0] fn,
	input  logic [7:0] vx,
	input  logic [7:0] vy,
	input  logic       vf_reset_mode,
	input  logic       shift_in_place,
	output alu_res_t   res
);

	logic [8:0] sum;
	logic [7:0] src;

	assign sum = {1'b0, vx} + {1'b0, vy};
	assign src = shift_in_place ? vx : vy;

	// Result, flag and whether the flag register is written.
	always_comb begin
		res = '{ok: 1'b1, res: 8'h00, vf_we: 1'b0, vf: 1'b0};
		case (fn)
			ALU_MOV: res.res = vy;
			ALU_OR:  begin res.res = vx | vy; res.vf_we = vf_reset_mode; end
			ALU_AND: begin res.res = vx & vy; res.vf_we = vf_reset_mode; end
			ALU_XOR: begin res.res = vx ^ vy; res.vf_we = vf_reset_mode; end
			ALU_ADD: begin res.res = sum[7:0]; res.vf_we = 1'b1; res.vf = sum[8]; end
			ALU_SUB: begin res.res = vx - vy; res.vf_we = 1'b1; res.vf = (vx >= vy); end
			ALU_SHR: begin res.res = {1'b0, src[7:1]}; res.vf_we = 1'b1; res.vf = src[0]; end
			ALU_SBN: begin res.res = vy - vx; res.vf_we = 1'b1; res.vf = (vy >= vx); end
			ALU_SHL: begin res.res = {src[6:0], 1'b0}; res.vf_we = 1'b1; res.vf = src[7]; end
			default: res.ok = 1'b0;
		endcase
	end

endmodule
